FILE: rtl/core/i2cbm_pkg.sv
// shared types and constants for the i2c master byte engine
package i2cbm_pkg;

  // sequencer state, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_READ  = 5'b01000,
    ST_STOP  = 5'b10000
  } seq_state_t;

  // command selector codes on the request channel
  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_START = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_STOP  = 3'd4;

  localparam logic [4:0] LenStart = 5'd4;
  localparam logic [4:0] LenStop  = 5'd5;
  localparam logic [4:0] LenByte  = 5'd27;

  localparam logic [2:0] TopBit   = 3'd7;
  localparam logic [1:0] PhaseLast = 2'd2;
  localparam logic [1:0] PhaseHigh = 2'd1;
  localparam logic [4:0] AckStep  = 5'd25;

  localparam logic [15:0] StepTicksRst = 16'd1;

  // register byte addresses
  localparam logic [2:0] ADDR_STEP_TICKS = 3'd0;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack;
    logic [7:0] rdata;
  } result_t;

endpackage

FILE: rtl/core/i2cbm_regs.sv
// apb register block holding the step length
module i2cbm_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] step_ticks
);

  logic [15:0] step_ticks_r;
  logic        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr == i2cbm_pkg::ADDR_STEP_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r <= i2cbm_pkg::StepTicksRst;
    end else if (wr_hit) begin
      step_ticks_r <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr)
      i2cbm_pkg::ADDR_STEP_TICKS: prdata = {16'd0, step_ticks_r};
      default:                    prdata = 32'd0;
    endcase
  end

  assign step_ticks = step_ticks_r;

endmodule

FILE: rtl/core/i2cbm_seq.sv
// pin step sequencer, advances one tick per accepted request
module i2cbm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  logic [2:0]          func,
  input  logic [7:0]          wdata,
  input  logic                sda_in,
  input  logic [15:0]         step_ticks,
  output i2cbm_pkg::result_t  res
);

  i2cbm_pkg::seq_state_t state_r, state_nxt, state_c;
  logic [4:0]  idx_r, idx_nxt, idx_c, idx_inc;
  logic [15:0] tick_r, tick_nxt, tick_c;
  logic [1:0]  phase_r, phase_nxt, phase_c;
  logic [3:0]  bit_r, bit_nxt, bit_c;
  logic [7:0]  shift_r, shift_nxt, shift_c;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  rdata_r, rdata_nxt;
  logic        done_c;
  logic [15:0] hold;
  logic        step_end;
  logic [4:0]  seq_len;

  assign hold     = (step_ticks == 16'd0) ? 16'd1 : step_ticks;
  assign step_end = ({1'b0, tick_c} + 17'd1) >= {1'b0, hold};
  assign idx_inc  = idx_c + 5'd1;

  always_comb begin
    state_c = state_r;
    idx_c   = idx_r;
    tick_c  = tick_r;
    phase_c = phase_r;
    bit_c   = bit_r;
    shift_c = shift_r;
    // a command is taken only while idle
    if (state_r == i2cbm_pkg::ST_IDLE) begin
      idx_c   = 5'd0;
      tick_c  = 16'd0;
      phase_c = 2'd0;
      bit_c   = 4'd0;
      unique case (func)
        i2cbm_pkg::FUNC_START: begin
          state_c = i2cbm_pkg::ST_START;
          shift_c = 8'd0;
        end
        i2cbm_pkg::FUNC_WRITE: begin
          state_c = i2cbm_pkg::ST_WRITE;
          shift_c = wdata;
        end
        i2cbm_pkg::FUNC_READ: begin
          state_c = i2cbm_pkg::ST_READ;
          shift_c = 8'd0;
        end
        i2cbm_pkg::FUNC_STOP: begin
          state_c = i2cbm_pkg::ST_STOP;
          shift_c = 8'd0;
        end
        default: state_c = i2cbm_pkg::ST_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_c)
      i2cbm_pkg::ST_START: seq_len = i2cbm_pkg::LenStart;
      i2cbm_pkg::ST_STOP:  seq_len = i2cbm_pkg::LenStop;
      default:             seq_len = i2cbm_pkg::LenByte;
    endcase
  end

  always_comb begin
    state_nxt = state_c;
    idx_nxt   = idx_c;
    tick_nxt  = tick_c;
    phase_nxt = phase_c;
    bit_nxt   = bit_c;
    shift_nxt = shift_c;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rdata_nxt = rdata_r;
    done_c    = 1'b0;
    if (state_c != i2cbm_pkg::ST_IDLE) begin
      // pin action on the first tick of a step
      if (tick_c == 16'd0) begin
        unique case (state_c)
          i2cbm_pkg::ST_START: begin
            unique case (idx_c)
              5'd0:    sda_nxt = 1'b1;
              5'd1:    scl_nxt = 1'b1;
              5'd2:    sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
          end
          i2cbm_pkg::ST_STOP: begin
            unique case (idx_c)
              5'd0:    sda_nxt = 1'b0;
              5'd1:    scl_nxt = 1'b1;
              5'd2:    sda_nxt = 1'b1;
              default: sda_nxt = sda_r;
            endcase
          end
          default: begin
            if (phase_c == 2'd0) begin
              if (state_c == i2cbm_pkg::ST_WRITE && !bit_c[3]) begin
                sda_nxt = shift_c[i2cbm_pkg::TopBit - bit_c[2:0]];
              end else begin
                sda_nxt = 1'b1;
              end
            end else if (phase_c == i2cbm_pkg::PhaseHigh) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end
        endcase
      end
      if (step_end) begin
        // sample sda at the end of the scl-high step
        if (state_c == i2cbm_pkg::ST_READ && !bit_c[3] &&
            phase_c == i2cbm_pkg::PhaseHigh) begin
          shift_nxt = {shift_c[6:0], sda_in};
        end else if (state_c == i2cbm_pkg::ST_WRITE && idx_c == i2cbm_pkg::AckStep) begin
          ack_nxt = ~sda_in;
        end
        tick_nxt = 16'd0;
        idx_nxt  = idx_inc;
        if (phase_c == i2cbm_pkg::PhaseLast) begin
          phase_nxt = 2'd0;
          bit_nxt   = bit_c + 4'd1;
        end else begin
          phase_nxt = phase_c + 2'd1;
        end
        if (idx_inc >= seq_len) begin
          if (state_c == i2cbm_pkg::ST_READ) begin
            rdata_nxt = shift_nxt;
          end
          state_nxt = i2cbm_pkg::ST_IDLE;
          idx_nxt   = 5'd0;
          done_c    = 1'b1;
        end
      end else begin
        tick_nxt = tick_c + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2cbm_pkg::ST_IDLE;
      idx_r   <= 5'd0;
      tick_r  <= 16'd0;
      phase_r <= 2'd0;
      bit_r   <= 4'd0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rdata_r <= 8'd0;
    end else if (tick) begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  assign res.scl_out  = scl_nxt;
  assign res.sda_out  = sda_nxt;
  assign res.busy_res = (state_nxt != i2cbm_pkg::ST_IDLE);
  assign res.done_res = done_c;
  assign res.ack      = ack_nxt;
  assign res.rdata    = rdata_nxt;

endmodule

FILE: rtl/core/i2cbm_outq.sv
// result register with a skid entry behind it
module i2cbm_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cbm_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cbm_pkg::result_t out_data
);

  i2cbm_pkg::result_t head_r, skid_r;
  logic head_valid_r, skid_valid_r;
  logic take;

  assign take = head_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid_r || take) begin
        head_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      head_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        head_r <= skid_r;
      end
    end else if (push) begin
      if (!head_valid_r || take) begin
        head_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

endmodule

FILE: rtl/core/i2c_bitbang_master_byte_engine_top.sv
// top level of the i2c master byte engine
//
//  channel   direction  handshake              payload
//  in_       request    in_valid / in_stall    in_func, in_wdata, in_sda_in
//  out_      result     out_valid / out_stall  out_scl_out .. out_rdata
//  apb       config     psel / penable         paddr, pwdata, prdata
//
// one request per clock cycle while in_stall is low; each request yields one result, held in a result register
// the sequencer updates its state in the cycle a request is accepted, and its result is pushed in that same cycle
// a two-entry result buffer keeps in_stall registered: it rises only when both entries are full
// synchronous active-low reset puts the lines released, the engine idle and step_ticks at 1
module i2c_bitbang_master_byte_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_wdata,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_ack,
  output logic [7:0]  out_rdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               accept;
  logic               full;
  logic [15:0]        step_ticks;
  i2cbm_pkg::result_t res;
  i2cbm_pkg::result_t out_data;

  assign accept   = in_valid & ~full;
  assign in_stall = full;

  i2cbm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .step_ticks (step_ticks)
  );

  i2cbm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (accept),
    .func       (in_func),
    .wdata      (in_wdata),
    .sda_in     (in_sda_in),
    .step_ticks (step_ticks),
    .res        (res)
  );

  i2cbm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_scl_out  = out_data.scl_out;
  assign out_sda_out  = out_data.sda_out;
  assign out_busy_res = out_data.busy_res;
  assign out_done_res = out_data.done_res;
  assign out_ack      = out_data.ack;
  assign out_rdata    = out_data.rdata;

endmodule
